/* rtl/octagon_term_index_decoder_assert.svh */
// Assertion macros shared by the octagon term index decoder RTL.
`ifndef OCTAGON_TERM_INDEX_DECODER_ASSERT_SVH
`define OCTAGON_TERM_INDEX_DECODER_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define OTID_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define OTID_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/otid_pkg.sv */
// Package with the widths, the pipeline bus type and the square root step function.
package otid_pkg;

    // Number of low index bits that take part in the decoding.
    localparam int INDEX_BITS      = 16;
    localparam int TERM_INDEX_W    = 16;
    localparam int FIRST_VAR_W     = 8;
    localparam int SECOND_VAR_W    = 9;

    // Root digits needed for the radicand floor(n/2) of INDEX_BITS-1 bits.
    localparam int ROOT_BASE       = INDEX_BITS / 2;
    localparam int STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES     = (ROOT_BASE + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int SQRT_STEPS      = SQRT_STAGES * STEPS_PER_STAGE;
    localparam int ROOT_W          = SQRT_STEPS;
    localparam int RAD_W           = 2 * SQRT_STEPS;
    localparam int REM_W           = ROOT_W + 2;
    localparam int DIFF_W          = REM_W + 1;
    localparam int CALC_W          = (DIFF_W > SECOND_VAR_W) ? DIFF_W : SECOND_VAR_W;

    // State of one index while its square root is being worked out.
    typedef struct packed {
        logic [RAD_W-1:0]  rad;   // radicand bits still to be consumed, top first
        logic              lsb;   // bit 0 of the index, dropped by the halving
        logic [ROOT_W-1:0] root;  // root digits found so far
        logic [REM_W-1:0]  rem;   // remainder of the digits consumed so far
    } t_sqrt_bus;

    // One digit-by-digit step: bring down two radicand bits, try a root bit of one.
    function automatic t_sqrt_bus sqrt_step(input t_sqrt_bus b);
        logic [REM_W-1:0] acc;
        logic [REM_W-1:0] trial;
        t_sqrt_bus        o;
        o     = b;
        acc   = {b.rem[REM_W-3:0], b.rad[RAD_W-1 -: 2]};
        trial = {b.root, 2'b01};
        o.rad = {b.rad[RAD_W-3:0], 2'b00};
        if (acc >= trial) begin
            o.rem  = acc - trial;
            o.root = {b.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = acc;
            o.root = {b.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

/* rtl/otid_root_stage.sv */
// One register stage of the pipelined integer square root, two root digits per stage.
module otid_root_stage import otid_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_sqrt_bus i_data,
    output logic      o_ready,
    output logic      o_valid,
    output t_sqrt_bus o_data,
    input  logic      i_ready
);

    logic      r_valid;
    t_sqrt_bus r_data;
    t_sqrt_bus n_data;

    always_comb begin
        n_data = i_data;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            n_data = sqrt_step(n_data);
        end
    end

    // The stage takes a new item whenever it is empty or its content moves on.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/otid_term_stage.sv */
// Final stage: splits the index into half and offset and registers the decoded term.
module otid_term_stage import otid_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_sqrt_bus               i_data,
    output logic                    o_ready,
    output logic                    o_valid,
    output logic                    o_first_negative,
    output logic [FIRST_VAR_W-1:0]  o_first_var,
    output logic                    o_second_negative,
    output logic [SECOND_VAR_W-1:0] o_second_var,
    input  logic                    i_ready
);

    logic                    r_valid;
    logic                    r_first_negative;
    logic [FIRST_VAR_W-1:0]  r_first_var;
    logic                    r_second_negative;
    logic [SECOND_VAR_W-1:0] r_second_var;

    logic [DIFF_W-1:0]       w_low_off;
    logic [DIFF_W-1:0]       w_half_len;
    logic                    w_lower;
    logic [DIFF_W-1:0]       w_off;
    logic [DIFF_W:0]         w_off_inc;
    logic [CALC_W-1:0]       w_half;
    logic [SECOND_VAR_W-1:0] n_second_var;

    // Since floor(n/2) = p*p + rem, the offset from 2p^2 is 2*rem + lsb.
    assign w_low_off  = {i_data.rem, i_data.lsb};
    assign w_half_len = DIFF_W'({i_data.root, 1'b1});
    assign w_lower    = w_low_off < w_half_len;
    assign w_off      = w_lower ? w_low_off : (w_low_off - w_half_len);

    // ceil(r/2) - 1; an offset of zero gives all ones, the single-variable code.
    assign w_off_inc    = {1'b0, w_off} + (DIFF_W + 1)'(1);
    assign w_half       = CALC_W'(w_off_inc[DIFF_W:1]);
    assign n_second_var = SECOND_VAR_W'(w_half - CALC_W'(1));

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_first_negative  <= w_lower;
            r_first_var       <= FIRST_VAR_W'(i_data.root);
            r_second_negative <= w_off[0];
            r_second_var      <= n_second_var;
        end
    end

    assign o_valid           = r_valid;
    assign o_first_negative  = r_first_negative;
    assign o_first_var       = r_first_var;
    assign o_second_negative = r_second_negative;
    assign o_second_var      = r_second_var;

endmodule

/* rtl/octagon_term_index_decoder.sv */
// Top level of the octagon term index decoder: square root pipeline and term stage.
//
// The block decodes a dense index n into an octagonal term "s1 x_a [s2 x_b]". It accepts
// one index per clock cycle while o_stall is low and returns one result per index, in
// order. Each index passes through SQRT_STAGES square root stages (four for 16-bit
// indices, two root digits each) and one term stage, whose register drives the outputs.
// The group p is the integer square root of floor(n/2), found digit by digit in the
// square root stages; the remainder of that root gives the offset from 2p^2 directly,
// so no multiplier is needed. Every stage holds one item and moves it on as soon as the
// next stage has room, so a stall on the output fills the pipeline before the input
// side sees o_stall. The block has no configuration and keeps no state between indices.
`include "octagon_term_index_decoder_assert.svh"

module octagon_term_index_decoder import otid_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [TERM_INDEX_W-1:0] i_term_index,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_first_negative,
    output logic [FIRST_VAR_W-1:0]  o_first_var,
    output logic                    o_second_negative,
    output logic [SECOND_VAR_W-1:0] o_second_var
);

    t_sqrt_bus             w_bus   [SQRT_STAGES+1];
    logic                  w_valid [SQRT_STAGES+1];
    logic                  w_ready [SQRT_STAGES+1];
    logic [INDEX_BITS-1:0] w_index;

    // Only the low INDEX_BITS bits of the index take part.
    assign w_index = INDEX_BITS'(i_term_index);

    // The square root pipeline starts from the halved index with an empty root.
    assign w_bus[0].rad  = RAD_W'(w_index >> 1);
    assign w_bus[0].lsb  = w_index[0];
    assign w_bus[0].root = '0;
    assign w_bus[0].rem  = '0;
    assign w_valid[0]    = i_valid;
    assign o_stall       = !w_ready[0];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_root
        otid_root_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_data  (w_bus[g]),
            .o_ready (w_ready[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_bus[g+1]),
            .i_ready (w_ready[g+1])
        );
    end

    // The term stage also serves as the output register.
    otid_term_stage u_term (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_valid[SQRT_STAGES]),
        .i_data            (w_bus[SQRT_STAGES]),
        .o_ready           (w_ready[SQRT_STAGES]),
        .o_valid           (o_valid),
        .o_first_negative  (o_first_negative),
        .o_first_var       (o_first_var),
        .o_second_negative (o_second_negative),
        .o_second_var      (o_second_var),
        .i_ready           (!i_stall)
    );

    // The input side is held off only when the output stage holds a result.
    `OTID_ASSERT_IMPLIES(a_stall_only_when_full, o_stall, o_valid,
        "input stalled with empty output")
    // Within a group the second variable is always below the first one.
    `OTID_ASSERT_IMPLIES(a_second_below_first, o_valid,
        o_second_var[SECOND_VAR_W-1] || (o_second_var[SECOND_VAR_W-2:0] < o_first_var),
        "second variable not below first")
    // A term with one variable carries the plus sign on its missing second part.
    `OTID_ASSERT_ALWAYS(a_single_var_plus,
        !o_valid || !(&o_second_var) || !o_second_negative,
        "single-variable term with minus sign")

endmodule
